// ===== rtl/core/wlpv_pkg.sv =====
// Shared types and constants for the weighted label plurality vote core.
// No dependencies; imported by the interfaces and every module of the core.
package wlpv_pkg;

  localparam int LABEL_W  = 16;
  localparam int WEIGHT_W = 16;
  localparam int TOTAL_W  = 22;

  localparam int MAX_DISTINCT_LABELS_DEF = 16;
  localparam int SUM_BITS_DEF            = 22;

  // depth of the queue between the front and the tally
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [LABEL_W-1:0]  label_key;
    logic [WEIGHT_W-1:0] vote_weight;
    logic                no_vote;
    logic                last_vote;
  } vote_t;

endpackage

// ===== rtl/core/wlpv_if.sv =====
// Valid/ready channel interfaces for vote beats and result beats.
// Depends on wlpv_pkg.
interface wlpv_vote_if
  import wlpv_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [LABEL_W-1:0]  label_key;
  logic [WEIGHT_W-1:0] vote_weight;
  logic                no_vote;
  logic                last_vote;

  modport source (output valid, label_key, vote_weight, no_vote, last_vote, input ready);
  modport sink   (input valid, label_key, vote_weight, no_vote, last_vote, output ready);
endinterface

interface wlpv_result_if
  import wlpv_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] winning_label;
  logic [TOTAL_W-1:0] winning_total;
  logic               missed_vertex;
  logic               table_overflow;

  modport source (output valid, winning_label, winning_total, missed_vertex, table_overflow,
                  input ready);
  modport sink   (input valid, winning_label, winning_total, missed_vertex, table_overflow,
                  output ready);
endinterface

// ===== rtl/core/wlpv_front.sv =====
// Front end: accepts vote beats, drops empty non-final beats, queues the rest.
// Depends on wlpv_pkg and wlpv_if.
module wlpv_front
  import wlpv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  wlpv_vote_if.sink    in_vote,
  output logic         q_valid,
  input  logic         q_ready,
  output vote_t        q_vote
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  vote_t              queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               accept, keep, push, pop;
  vote_t              beat;

  assign in_vote.ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign accept        = in_vote.valid && in_vote.ready;

  // a no-vote beat that does not close the run changes nothing downstream
  assign keep = !in_vote.no_vote || in_vote.last_vote;
  assign push = accept && keep;

  assign q_valid = (count_r != '0);
  assign pop     = q_valid && q_ready;
  assign q_vote  = queue_r[rd_ptr_r];

  always_comb begin
    beat.label_key   = in_vote.label_key;
    beat.vote_weight = in_vote.vote_weight;
    beat.no_vote     = in_vote.no_vote;
    beat.last_vote   = in_vote.last_vote;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= beat;
    end
  end

endmodule

// ===== rtl/core/wlpv_tally.sv =====
// Back end: per-key tally cells, end-of-run winner scan and result register.
// Depends on wlpv_pkg and wlpv_if.
module wlpv_tally
  import wlpv_pkg::*;
#(
  parameter int MAX_DISTINCT_LABELS = MAX_DISTINCT_LABELS_DEF,
  parameter int SUM_BITS            = SUM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  vote_t              q_vote,
  input  logic [LABEL_W-1:0] unassigned_key,
  wlpv_result_if.source      out_result
);

  localparam int IDX_W = $clog2(MAX_DISTINCT_LABELS);
  localparam int CNT_W = $clog2(MAX_DISTINCT_LABELS + 1);

  typedef enum logic [1:0] {
    S_VOTE,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [LABEL_W-1:0]   key_r [MAX_DISTINCT_LABELS];
  logic [SUM_BITS-1:0]  sum_r [MAX_DISTINCT_LABELS];
  logic [LABEL_W-1:0]   key_nxt [MAX_DISTINCT_LABELS];
  logic [SUM_BITS-1:0]  sum_nxt [MAX_DISTINCT_LABELS];
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CNT_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic [LABEL_W-1:0]   best_key_r, best_key_nxt;
  logic [SUM_BITS-1:0]  best_sum_r, best_sum_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [LABEL_W-1:0]   out_label_r, out_label_nxt;
  logic [TOTAL_W-1:0]   out_total_r, out_total_nxt;
  logic                 out_missed_r, out_missed_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  logic [MAX_DISTINCT_LABELS-1:0] hit;
  logic                 any_hit, vote, load;
  logic [SUM_BITS:0]    sum_ext;
  logic [LABEL_W-1:0]   cand_key;
  logic [SUM_BITS-1:0]  cand_sum;

  assign q_ready = (state_r == S_VOTE);
  assign vote    = q_valid && q_ready && !q_vote.no_vote;
  assign load    = (state_r == S_EMIT) && (!out_valid_r || out_result.ready);

  // every live cell compares its key against the incoming beat
  always_comb begin
    for (int i = 0; i < MAX_DISTINCT_LABELS; i++) begin
      hit[i] = (CNT_W'(i) < used_r) && (key_r[i] == q_vote.label_key);
    end
  end
  assign any_hit = |hit;

  always_comb begin
    used_nxt = used_r;
    ovf_nxt  = ovf_r;
    sum_ext  = '0;
    for (int i = 0; i < MAX_DISTINCT_LABELS; i++) begin
      key_nxt[i] = key_r[i];
      sum_nxt[i] = sum_r[i];
      if (vote && hit[i]) begin
        sum_ext = (SUM_BITS + 1)'(sum_r[i]) + (SUM_BITS + 1)'(q_vote.vote_weight);
        sum_nxt[i] = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
      end
    end
    if (vote && !any_hit) begin
      if (used_r < CNT_W'(MAX_DISTINCT_LABELS)) begin
        key_nxt[used_r[IDX_W-1:0]] = q_vote.label_key;
        sum_nxt[used_r[IDX_W-1:0]] = SUM_BITS'(q_vote.vote_weight);
        used_nxt = used_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (load) begin
      used_nxt = '0;
      ovf_nxt  = 1'b0;
    end
  end

  assign cand_key = key_r[scan_idx_r[IDX_W-1:0]];
  assign cand_sum = sum_r[scan_idx_r[IDX_W-1:0]];

  always_comb begin
    state_nxt      = state_r;
    scan_idx_nxt   = scan_idx_r;
    best_key_nxt   = best_key_r;
    best_sum_nxt   = best_sum_r;
    out_valid_nxt  = out_valid_r && !out_result.ready;
    out_label_nxt  = out_label_r;
    out_total_nxt  = out_total_r;
    out_missed_nxt = out_missed_r;
    out_ovf_nxt    = out_ovf_r;
    unique case (state_r)
      S_VOTE: begin
        if (q_valid && q_vote.last_vote) begin
          state_nxt    = S_SCAN;
          scan_idx_nxt = '0;
        end
      end
      S_SCAN: begin
        if (scan_idx_r < used_r) begin
          // larger sum wins; equal sums go to the smaller key
          if (scan_idx_r == '0 || cand_sum > best_sum_r ||
              (cand_sum == best_sum_r && cand_key < best_key_r)) begin
            best_key_nxt = cand_key;
            best_sum_nxt = cand_sum;
          end
          scan_idx_nxt = scan_idx_r + 1'b1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load) begin
          state_nxt      = S_VOTE;
          out_valid_nxt  = 1'b1;
          out_missed_nxt = (used_r == '0);
          out_ovf_nxt    = ovf_r;
          if (used_r == '0) begin
            out_label_nxt = unassigned_key;
            out_total_nxt = '0;
          end else begin
            out_label_nxt = best_key_r;
            out_total_nxt = TOTAL_W'(best_sum_r);
          end
        end
      end
      default: state_nxt = S_VOTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_VOTE;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
      scan_idx_r   <= scan_idx_nxt;
      best_key_r   <= best_key_nxt;
      best_sum_r   <= best_sum_nxt;
      out_label_r  <= out_label_nxt;
      out_total_r  <= out_total_nxt;
      out_missed_r <= out_missed_nxt;
      out_ovf_r    <= out_ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_DISTINCT_LABELS; i++) begin
      key_r[i] <= key_nxt[i];
      sum_r[i] <= sum_nxt[i];
    end
  end

  assign out_result.valid          = out_valid_r;
  assign out_result.winning_label  = out_label_r;
  assign out_result.winning_total  = out_total_r;
  assign out_result.missed_vertex  = out_missed_r;
  assign out_result.table_overflow = out_ovf_r;

`ifndef SYNTHESIS
  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(MAX_DISTINCT_LABELS))
    else $error("tally entry count above capacity");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (used_r == '0) && !ovf_r && out_valid_r)
    else $error("table not cleared after result load");

  a_missed_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_missed_r) |-> (out_total_r == '0))
    else $error("missed vertex with nonzero total");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_idx_r <= used_r))
    else $error("scan index ran past live entries");
`endif

endmodule

// ===== rtl/core/weighted_label_plurality_vote_core.sv =====
// Top level of the weighted label plurality vote core: config register, front, tally.
// Depends on wlpv_pkg, wlpv_if, wlpv_front and wlpv_tally.
//
// Votes for one vertex stream in on in_vote; the beat with last_vote closes the run and
// yields one beat on out_result. While a run streams, the tally takes one vote per cycle:
// every table cell compares its key in parallel. Beats with no_vote set and last_vote
// clear are discarded at entry. Closing a run takes the tally through a winner scan over
// each live entry, a step to close the scan and a load of the result register, which waits
// for a free output slot; a 4-beat queue in front keeps accepting during that time.
// Ties go to the smaller key, sums saturate at 2^SUM_BITS - 1, and a new key arriving at a
// full table is dropped and flagged in table_overflow. A run with no votes reports
// cfg_wdata's last value as the label with missed_vertex set.
module weighted_label_plurality_vote_core
  import wlpv_pkg::*;
#(
  parameter int MAX_DISTINCT_LABELS = MAX_DISTINCT_LABELS_DEF,
  parameter int SUM_BITS            = SUM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [LABEL_W-1:0] cfg_wdata,
  wlpv_vote_if.sink          in_vote,
  wlpv_result_if.source      out_result
);

  logic [LABEL_W-1:0] unassigned_key_r;
  logic               q_valid;
  logic               q_ready;
  vote_t              q_vote;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unassigned_key_r <= '0;
    end else if (cfg_we) begin
      unassigned_key_r <= cfg_wdata;
    end
  end

  wlpv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vote (in_vote),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_vote  (q_vote)
  );

  wlpv_tally #(
    .MAX_DISTINCT_LABELS (MAX_DISTINCT_LABELS),
    .SUM_BITS            (SUM_BITS)
  ) u_tally (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_vote         (q_vote),
    .unassigned_key (unassigned_key_r),
    .out_result     (out_result)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for weighted_label_plurality_vote_core: random vote runs, scored winners.
// Depends on wlpv_pkg, wlpv_vote_if, wlpv_result_if and weighted_label_plurality_vote_core from the core's RTL.
module testbench;
  import wlpv_pkg::*;

  localparam int TABLE_DEPTH   = MAX_DISTINCT_LABELS_DEF;
  localparam longint SUM_LIMIT = (64'd1 << SUM_BITS_DEF) - 1;
  localparam int PHASE_VOTES   = 380;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int MAX_REPORTS   = 50;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [TOTAL_W-1:0] total;
    logic               missed;
    logic               overflow;
  } winner_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [LABEL_W-1:0] cfg_wdata;

  wlpv_vote_if   vote_bus ();
  wlpv_result_if result_bus ();

  weighted_label_plurality_vote_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_vote    (vote_bus),
    .out_result (result_bus)
  );

  // tally mirror
  logic [LABEL_W-1:0] tally_keys [TABLE_DEPTH];
  longint unsigned    tally_sums [TABLE_DEPTH];
  int                 tally_count   = 0;
  bit                 tally_dropped = 1'b0;
  logic [LABEL_W-1:0] empty_label   = '0;

  vote_t   pending_votes [$];
  winner_t expected_winners [$];

  int  phase_votes;
  int  results_seen    = 0;
  int  failures        = 0;
  int  cycle_count     = 0;
  bit  vote_taken      = 1'b0;
  int  burst_left      = 0;
  int  gap_left        = 0;
  int  hold_left       = 0;
  bit  hold_used       = 1'b0;
  int  stall_tick      = 0;
  rx_mode_t stall_mode = RX_OPEN;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void tally_vote(logic [LABEL_W-1:0] key, logic [WEIGHT_W-1:0] weight);
    longint unsigned s;
    for (int i = 0; i < tally_count; i++) begin
      if (tally_keys[i] == key) begin
        s = tally_sums[i] + weight;
        tally_sums[i] = (s > SUM_LIMIT) ? SUM_LIMIT : s;
        return;
      end
    end
    if (tally_count < TABLE_DEPTH) begin
      tally_keys[tally_count] = key;
      tally_sums[tally_count] = weight;
      tally_count++;
    end else begin
      tally_dropped = 1'b1;
    end
  endfunction

  function automatic winner_t close_run();
    winner_t w;
    w.overflow = tally_dropped;
    if (tally_count == 0) begin
      w.label  = empty_label;
      w.total  = '0;
      w.missed = 1'b1;
    end else begin
      w.label  = tally_keys[0];
      w.total  = TOTAL_W'(tally_sums[0]);
      w.missed = 1'b0;
      for (int i = 1; i < tally_count; i++) begin
        if (tally_sums[i] > w.total || (tally_sums[i] == w.total && tally_keys[i] < w.label)) begin
          w.label = tally_keys[i];
          w.total = TOTAL_W'(tally_sums[i]);
        end
      end
    end
    tally_count   = 0;
    tally_dropped = 1'b0;
    return w;
  endfunction

  task automatic report(string field, longint unsigned want, longint unsigned got);
    failures++;
    if (failures <= MAX_REPORTS)
      $error("%s: expected %0h, actual %0h", field, want, got);
  endtask

  // input acceptance, prediction and result scoring
  always @(posedge clk) begin
    winner_t want;
    if (!rst_n) begin
      vote_taken <= 1'b0;
    end else begin
      vote_taken <= vote_bus.valid && vote_bus.ready;
      if (cfg_we)
        empty_label = cfg_wdata;
      if (vote_bus.valid && vote_bus.ready) begin
        if (!vote_bus.no_vote)
          tally_vote(vote_bus.label_key, vote_bus.vote_weight);
        if (vote_bus.last_vote)
          expected_winners.push_back(close_run());
      end
      if (result_bus.valid && result_bus.ready) begin
        results_seen++;
        if (expected_winners.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $error("result beat with nothing expected: label %0h", result_bus.winning_label);
        end else begin
          want = expected_winners.pop_front();
          if (result_bus.winning_label !== want.label)
            report("winning_label", want.label, result_bus.winning_label);
          if (result_bus.winning_total !== want.total)
            report("winning_total", want.total, result_bus.winning_total);
          if (result_bus.missed_vertex !== want.missed)
            report("missed_vertex", want.missed, result_bus.missed_vertex);
          if (result_bus.table_overflow !== want.overflow)
            report("table_overflow", want.overflow, result_bus.table_overflow);
        end
      end
    end
  end

  // sender: bursts of beats separated by random gaps
  always @(negedge clk) begin
    vote_t v;
    if (!rst_n) begin
      vote_bus.valid <= 1'b0;
    end else if (vote_bus.valid && !vote_taken) begin
      // hold the beat until it is taken
    end else if (gap_left > 0) begin
      gap_left--;
      vote_bus.valid <= 1'b0;
    end else if (pending_votes.size() > 0) begin
      v = pending_votes.pop_front();
      vote_bus.valid       <= 1'b1;
      vote_bus.label_key   <= v.label_key;
      vote_bus.vote_weight <= v.vote_weight;
      vote_bus.no_vote     <= v.no_vote;
      vote_bus.last_vote   <= v.last_vote;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      vote_bus.valid <= 1'b0;
    end
  end

  // receiver: stall pattern by mode, plus one long hold-off to back up the core
  always @(negedge clk) begin
    if (!rst_n) begin
      result_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_bus.ready <= 1'b0;
    end else if (!hold_used && results_seen >= 40) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
      result_bus.ready <= 1'b0;
    end else begin
      stall_tick++;
      if (stall_tick % 64 == 0)
        stall_mode = rx_mode_t'($urandom_range(0, 3));
      case (stall_mode)
        RX_OPEN:     result_bus.ready <= 1'b1;
        RX_RANDOM:   result_bus.ready <= ($urandom_range(0, 9) < 7);
        RX_PERIODIC: result_bus.ready <= (stall_tick % 5 != 0);
        default:     result_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_vote(logic [LABEL_W-1:0] key, logic [WEIGHT_W-1:0] weight,
                           logic skip, logic last);
    vote_t v;
    v.label_key   = key;
    v.vote_weight = weight;
    v.no_vote     = skip;
    v.last_vote   = last;
    pending_votes.push_back(v);
    // no_vote beats that do not close a run are dropped at entry
    if (!skip || last)
      phase_votes++;
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 3))
      0:       return WEIGHT_W'($urandom);
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      2:       return WEIGHT_W'($urandom_range(1, 15) << 12);
      default: return WEIGHT_W'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic queue_run(int kind);
    int n;
    logic [LABEL_W-1:0] pool [3];
    logic [LABEL_W-1:0] base;
    foreach (pool[i]) pool[i] = LABEL_W'($urandom);
    base = LABEL_W'($urandom);
    if (kind < 6) begin
      n = $urandom_range(0, 3);
      repeat (n) push_vote(LABEL_W'($urandom), WEIGHT_W'($urandom), 1'b1, 1'b0);
      push_vote(LABEL_W'($urandom), WEIGHT_W'($urandom), 1'b1, 1'b1);
    end else if (kind < 62) begin
      // few keys, coarse weights: ties are common
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
        push_vote(pool[$urandom_range(0, 2)], pick_weight(),
                  ($urandom_range(0, 9) == 0), (i == n - 1));
    end else if (kind < 80) begin
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++)
        push_vote(LABEL_W'($urandom), pick_weight(), ($urandom_range(0, 19) == 0),
                  (i == n - 1));
    end else if (kind < 98) begin
      // near or past table capacity, repeats mixed in
      n = $urandom_range(12, 24);
      for (int i = 0; i < n; i++)
        push_vote(($urandom_range(0, 3) == 0) ? LABEL_W'(base + $urandom_range(0, i))
                                              : LABEL_W'(base + i),
                  pick_weight(), 1'b0, (i == n - 1));
    end else begin
      // long run of heavy votes on two keys: sums grow large
      n = $urandom_range(64, 72);
      for (int i = 0; i < n; i++)
        push_vote(pool[$urandom_range(0, 1)], WEIGHT_W'($urandom_range(16'hF000, 16'hFFFF)),
                  1'b0, (i == n - 1));
    end
  endtask

  // checked at the rising edge, where the bus and the queues are settled
  task automatic wait_drained();
    while (pending_votes.size() != 0 || vote_bus.valid || expected_winners.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_empty_label(logic [LABEL_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [LABEL_W-1:0] label_settings [5];
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    vote_bus.valid        = 1'b0;
    vote_bus.label_key    = '0;
    vote_bus.vote_weight  = '0;
    vote_bus.no_vote      = 1'b0;
    vote_bus.last_vote    = 1'b0;
    result_bus.ready      = 1'b0;
    label_settings = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'h0000};
    label_settings[4] = LABEL_W'($urandom);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty run under the reset label, extremes, zero sum, tie, full table
    push_vote(16'h1234, 16'h5678, 1'b1, 1'b1);
    push_vote(16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
    push_vote(16'h0000, 16'h0000, 1'b0, 1'b1);
    push_vote(16'h0005, 16'h0100, 1'b0, 1'b0);
    push_vote(16'h0003, 16'h0100, 1'b0, 1'b0);
    push_vote(16'h0009, 16'h0050, 1'b1, 1'b1);
    for (int i = 0; i < 17; i++)
      push_vote(LABEL_W'(16'h0100 + i), WEIGHT_W'(i << 8), 1'b0, 1'b0);
    push_vote(16'h0100, 16'h0010, 1'b0, 1'b1);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_empty_label(label_settings[p]);
      @(posedge clk);
      phase_votes = 0;
      push_vote(LABEL_W'($urandom), WEIGHT_W'($urandom), 1'b1, 1'b1);
      if (p == 0)
        queue_run(99);
      while (phase_votes < PHASE_VOTES)
        queue_run($urandom_range(0, 99));
      wait_drained();
    end

    if (failures == 0 && expected_winners.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
